// ===== hw/rtl/fmrb_pkg.sv =====
// package: shared constants, codes and types of the framed message ring buffer
package fmrb_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int HDR_BYTES = 6;

    localparam logic [26:0] SERIAL_MAX = 27'd99999999;
    localparam logic [11:0] MAX_LEN_RESET = 12'd2048;
    localparam logic [11:0] COUNT_MAX = 12'd4095;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_CAP   = 3'd2,
        ST_BAD   = 3'd3,
        ST_REJ   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEPT = 2'd1,
        PH_DROP   = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_HDR  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_byte_out;
        logic [15:0] head_length;
        logic [26:0] serial;
        logic        last_of_message;
        logic [11:0] message_count;
        logic [11:0] free_bytes;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== hw/rtl/fmrb_if.sv =====
// interfaces: input word channel and result word channel
interface fmrb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [15:0] message_length;
    logic        last;
    logic [15:0] reader_capacity;
    logic [10:0] peek_offset;

    modport source (output valid, operation, data_byte, message_length, last,
                    reader_capacity, peek_offset, input ready);
    modport sink (input valid, operation, data_byte, message_length, last,
                  reader_capacity, peek_offset, output ready);
endinterface

interface fmrb_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  data_byte_out;
    logic [15:0] head_length;
    logic [26:0] serial;
    logic        last_of_message;
    logic [11:0] message_count;
    logic [11:0] free_bytes;

    modport source (output valid, status, data_byte_out, head_length, serial,
                    last_of_message, message_count, free_bytes, input ready);
    modport sink (input valid, status, data_byte_out, head_length, serial,
                  last_of_message, message_count, free_bytes, output ready);
endinterface

// ===== hw/rtl/fmrb_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module fmrb_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/fmrb_ctrl.sv =====
// sequencer: fetches head header and data byte, executes the word, writes back
module fmrb_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    fmrb_in_if.sink                  in_ch,
    input  logic                     cfg_we,
    input  logic [11:0]              cfg_wdata,
    output fmrb_pkg::mem_req_t       mem_req,
    input  logic [7:0]               mem_rdata,
    input  logic                     res_free,
    output logic                     res_load,
    output fmrb_pkg::result_t        res
);

    localparam int AW = fmrb_pkg::ADDR_W;

    fmrb_pkg::state_t state_reg, state_next;
    logic [2:0]       idx_reg, idx_next;

    // captured word
    logic [1:0]  op_reg;
    logic [7:0]  din_reg;
    logic [15:0] mlen_reg;
    logic        last_reg;
    logic [15:0] cap_reg;
    logic [10:0] poff_reg;

    // fetched header bytes and data byte
    logic [7:0] byte_reg [7];

    // ring state
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] cwp_reg, cwp_next;
    logic [AW-1:0] wcur_reg, wcur_next;
    logic [11:0]   taken_reg, taken_next;
    logic [11:0]   wlen_reg, wlen_next;
    fmrb_pkg::phase_t phase_reg, phase_next;
    logic [11:0]   roff_reg, roff_next;
    logic [26:0]   ser_reg, ser_next;
    logic [11:0]   cnt_reg, cnt_next;
    logic [11:0]   maxlen_reg;

    // header write-back
    logic [47:0]   hword_reg;
    logic [AW-1:0] hbase_reg;
    logic          hdr_go;

    logic [AW-1:0] hp;
    logic          empty;
    logic [15:0]   hlen;
    logic [31:0]   hser;
    logic [26:0]   nser;
    logic [AW-1:0] free_now;
    logic [11:0]   data_off;
    logic          fire;
    logic [2:0]    status;
    logic [7:0]    dout;
    logic          lastout;
    logic          mlen_bad;
    logic          hlen_bad;
    logic          dwe;

    assign in_ch.ready = (state_reg == fmrb_pkg::S_IDLE);
    assign fire        = (state_reg == fmrb_pkg::S_EXEC) && res_free;
    assign res_load    = fire;

    // head view, valid once the fetch is done
    assign hp       = rp_reg + AW'(1);
    assign empty    = (hp == cwp_reg);
    assign hlen     = empty ? 16'd0 : {byte_reg[0], byte_reg[1]};
    assign hser     = empty ? 32'd0 : {byte_reg[2], byte_reg[3], byte_reg[4], byte_reg[5]};
    assign nser     = (ser_reg >= fmrb_pkg::SERIAL_MAX) ? 27'd0 : ser_reg + 27'd1;
    assign free_now = rp_reg - cwp_reg - AW'(1);
    assign data_off = (op_reg == fmrb_pkg::OP_PEEK) ? {1'b0, poff_reg} : roff_reg;

    assign mlen_bad = (mlen_reg == 16'd0) ||
                      ((maxlen_reg != 12'd0) && (mlen_reg > {4'd0, maxlen_reg}));
    assign hlen_bad = (hlen == 16'd0) ||
                      ((maxlen_reg != 12'd0) && (hlen > {4'd0, maxlen_reg}));

    // memory port: fetch address, data write in exec, header write-back
    always_comb
    begin
        mem_req.raddr = hp + AW'(idx_reg);
        if (idx_reg == 3'd6)
        begin
            mem_req.raddr = hp + AW'(fmrb_pkg::HDR_BYTES) + data_off[AW-1:0];
        end
        if (state_reg == fmrb_pkg::S_HDR)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hbase_reg + AW'(idx_reg);
            mem_req.wdata = hword_reg[47 - 8*idx_reg -: 8];
        end
        else
        begin
            mem_req.we    = fire && dwe;
            mem_req.waddr = wcur_next - AW'(1);
            mem_req.wdata = din_reg;
        end
    end

    // execution of one word
    always_comb
    begin
        rp_next    = rp_reg;
        cwp_next   = cwp_reg;
        wcur_next  = wcur_reg;
        taken_next = taken_reg;
        wlen_next  = wlen_reg;
        phase_next = phase_reg;
        roff_next  = roff_reg;
        ser_next   = ser_reg;
        cnt_next   = cnt_reg;
        status     = fmrb_pkg::ST_OK;
        dout       = 8'd0;
        lastout    = 1'b0;
        hdr_go     = 1'b0;
        dwe        = 1'b0;
        case (op_reg)
            fmrb_pkg::OP_WRITE:
            begin
                if (phase_reg == fmrb_pkg::PH_IDLE)
                begin
                    if (mlen_bad || ({5'd0, free_now} < {1'b0, mlen_reg} + 17'd6))
                    begin
                        status     = fmrb_pkg::ST_REJ;
                        phase_next = last_reg ? fmrb_pkg::PH_IDLE : fmrb_pkg::PH_DROP;
                    end
                    else
                    begin
                        hdr_go     = 1'b1;
                        wcur_next  = cwp_reg + AW'(fmrb_pkg::HDR_BYTES);
                        taken_next = 12'd0;
                        wlen_next  = mlen_reg[11:0];
                        phase_next = fmrb_pkg::PH_ACCEPT;
                    end
                end
                else if (phase_reg == fmrb_pkg::PH_DROP)
                begin
                    status = fmrb_pkg::ST_REJ;
                    if (last_reg)
                    begin
                        phase_next = fmrb_pkg::PH_IDLE;
                    end
                end
                if ((phase_next == fmrb_pkg::PH_ACCEPT) && (status == fmrb_pkg::ST_OK))
                begin
                    if (taken_next >= wlen_next)
                    begin
                        status     = fmrb_pkg::ST_REJ;
                        phase_next = last_reg ? fmrb_pkg::PH_IDLE : fmrb_pkg::PH_DROP;
                    end
                    else
                    begin
                        dwe        = 1'b1;
                        wcur_next  = wcur_next + AW'(1);
                        taken_next = taken_next + 12'd1;
                        if (last_reg)
                        begin
                            if (taken_next == wlen_next)
                            begin
                                cwp_next = wcur_next;
                                ser_next = nser;
                                if (cnt_reg < fmrb_pkg::COUNT_MAX)
                                begin
                                    cnt_next = cnt_reg + 12'd1;
                                end
                            end
                            else
                            begin
                                status = fmrb_pkg::ST_REJ;
                            end
                            phase_next = fmrb_pkg::PH_IDLE;
                        end
                    end
                end
            end
            fmrb_pkg::OP_READ:
            begin
                if (empty)
                begin
                    status = fmrb_pkg::ST_EMPTY;
                end
                else if ((roff_reg == 12'd0) && hlen_bad)
                begin
                    status   = fmrb_pkg::ST_BAD;
                    rp_next  = cwp_reg - AW'(1);
                    cnt_next = 12'd0;
                end
                else if ((roff_reg == 12'd0) && (cap_reg < hlen))
                begin
                    status = fmrb_pkg::ST_CAP;
                end
                else
                begin
                    dout      = byte_reg[6];
                    roff_next = roff_reg + 12'd1;
                    if ({4'd0, roff_next} >= hlen)
                    begin
                        rp_next   = rp_reg + AW'(fmrb_pkg::HDR_BYTES) + hlen[AW-1:0];
                        roff_next = 12'd0;
                        lastout   = 1'b1;
                        if (cnt_reg != 12'd0)
                        begin
                            cnt_next = cnt_reg - 12'd1;
                        end
                    end
                end
            end
            fmrb_pkg::OP_PEEK:
            begin
                if (empty)
                begin
                    status = fmrb_pkg::ST_EMPTY;
                end
                else if (hlen_bad)
                begin
                    status = fmrb_pkg::ST_BAD;
                end
                else if (cap_reg < hlen)
                begin
                    status = fmrb_pkg::ST_CAP;
                end
                else if ({5'd0, poff_reg} < hlen)
                begin
                    dout = byte_reg[6];
                end
            end
            default:
            begin
                rp_next    = AW'(0);
                cwp_next   = AW'(1);
                wcur_next  = AW'(1);
                taken_next = 12'd0;
                phase_next = fmrb_pkg::PH_IDLE;
                roff_next  = 12'd0;
                cnt_next   = 12'd0;
            end
        endcase
    end

    // result word
    always_comb
    begin
        res.status          = status;
        res.data_byte_out   = dout;
        res.head_length     = hlen;
        res.serial          = (op_reg == fmrb_pkg::OP_WRITE) ? nser : hser[26:0];
        res.last_of_message = lastout;
        res.message_count   = cnt_next;
        res.free_bytes      = 12'(rp_next - cwp_next - AW'(1));
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            fmrb_pkg::S_IDLE:
            begin
                idx_next = 3'd0;
                if (in_ch.valid)
                begin
                    state_next = fmrb_pkg::S_READ;
                end
            end
            fmrb_pkg::S_READ:
            begin
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    state_next = fmrb_pkg::S_EXEC;
                    idx_next   = 3'd0;
                end
            end
            fmrb_pkg::S_EXEC:
            begin
                if (fire)
                begin
                    state_next = hdr_go ? fmrb_pkg::S_HDR : fmrb_pkg::S_IDLE;
                    idx_next   = 3'd0;
                end
            end
            fmrb_pkg::S_HDR:
            begin
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'(fmrb_pkg::HDR_BYTES - 1))
                begin
                    state_next = fmrb_pkg::S_IDLE;
                    idx_next   = 3'd0;
                end
            end
            default:
            begin
                state_next = fmrb_pkg::S_IDLE;
                idx_next   = 3'd0;
            end
        endcase
    end

    // control and ring state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fmrb_pkg::S_IDLE;
            idx_reg    <= 3'd0;
            rp_reg     <= AW'(0);
            cwp_reg    <= AW'(1);
            wcur_reg   <= AW'(1);
            taken_reg  <= 12'd0;
            wlen_reg   <= 12'd0;
            phase_reg  <= fmrb_pkg::PH_IDLE;
            roff_reg   <= 12'd0;
            ser_reg    <= 27'd0;
            cnt_reg    <= 12'd0;
            maxlen_reg <= fmrb_pkg::MAX_LEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                maxlen_reg <= cfg_wdata;
            end
            if (fire)
            begin
                rp_reg    <= rp_next;
                cwp_reg   <= cwp_next;
                wcur_reg  <= wcur_next;
                taken_reg <= taken_next;
                wlen_reg  <= wlen_next;
                phase_reg <= phase_next;
                roff_reg  <= roff_next;
                ser_reg   <= ser_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    // captured word, fetched bytes and header image
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg   <= in_ch.operation;
            din_reg  <= in_ch.data_byte;
            mlen_reg <= in_ch.message_length;
            last_reg <= in_ch.last;
            cap_reg  <= in_ch.reader_capacity;
            poff_reg <= in_ch.peek_offset;
        end
        if ((state_reg == fmrb_pkg::S_READ) && (idx_reg != 3'd0))
        begin
            byte_reg[idx_reg - 3'd1] <= mem_rdata;
        end
        if (fire)
        begin
            hword_reg <= {mlen_reg, 5'd0, nser};
            hbase_reg <= cwp_reg;
        end
    end

endmodule

// ===== hw/rtl/framed_message_ring_buffer_unit.sv =====
// flow: the six header bytes and the data byte are fetched one at a time through
// the single read port; the word executes once the result register is free, and a
// write that opens a message then writes back its header before the next word is
// taken; a new word is taken only once the last one is through
// reset: rst_n clears pointers, count, serial, sets limit 2048 at once; ring ram kept
module framed_message_ring_buffer_unit (
    input  logic        clk,
    input  logic        rst_n,
    fmrb_in_if.sink     in_ch,
    fmrb_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);

    fmrb_pkg::mem_req_t mem_req;
    logic [7:0]         mem_rdata;
    fmrb_pkg::result_t  res;
    fmrb_pkg::result_t  res_reg;
    logic               res_load;
    logic               out_valid_reg;
    logic               res_free;

    assign res_free = !out_valid_reg || out_ch.ready;

    fmrb_ram #(
        .ADDR_W (fmrb_pkg::ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    fmrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_free  (res_free),
        .res_load  (res_load),
        .res       (res)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.status          = res_reg.status;
    assign out_ch.data_byte_out   = res_reg.data_byte_out;
    assign out_ch.head_length     = res_reg.head_length;
    assign out_ch.serial          = res_reg.serial;
    assign out_ch.last_of_message = res_reg.last_of_message;
    assign out_ch.message_count   = res_reg.message_count;
    assign out_ch.free_bytes      = res_reg.free_bytes;

endmodule

// ===== tb/tb_framed_message_ring_buffer_unit.sv =====
// testbench: framed message ring buffer unit, self-checking against a predictor of its ring state
module tb_framed_message_ring_buffer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 4096;
    localparam int SERIAL_WRAP = 100000000;

    typedef struct {
        fmrb_pkg::op_t op;
        logic [7:0]    data;
        logic [15:0]   len;
        logic          last;
        logic [15:0]   cap;
        logic [10:0]   poff;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_wdata;

    fmrb_in_if  in_ch ();
    fmrb_out_if out_ch ();

    framed_message_ring_buffer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predicted ring state
    logic [7:0]       ring_mem [RING];
    int               rd_ptr;
    int               commit_ptr;
    int               wr_cursor;
    int               wr_taken;
    fmrb_pkg::phase_t wr_phase;
    int               rd_offset;
    int               serial_cnt;
    int               msg_count;
    int               max_len;

    word_t             pending_words[$];
    fmrb_pkg::result_t expected_results[$];
    word_t             cur_word;
    bit                offering;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                rx_hold_left;
    int                mismatches;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #12000000;
        $display("status: fail");
        $finish;
    end

    function automatic bit length_bad(input int len);
        return len == 0 || (max_len != 0 && len > max_len);
    endfunction

    function automatic int ring_free();
        return (rd_ptr + RING - commit_ptr + RING - 1) % RING;
    endfunction

    // work out the result of one accepted word and advance the ring state
    function automatic void predict_ring_word(input word_t w);
        fmrb_pkg::result_t r;
        int hp, hlen, hser, ser, wlen, base;
        bit empty;
        hp = (rd_ptr + 1) % RING;
        empty = (hp == commit_ptr);
        hlen = 0;
        hser = 0;
        r = '0;
        r.status = fmrb_pkg::ST_OK;
        if (!empty)
        begin
            hlen = {ring_mem[hp], ring_mem[(hp + 1) % RING]};
            hser = {ring_mem[(hp + 2) % RING], ring_mem[(hp + 3) % RING],
                    ring_mem[(hp + 4) % RING], ring_mem[(hp + 5) % RING]};
        end
        r.serial = 27'(hser);
        case (w.op)
            fmrb_pkg::OP_WRITE:
            begin
                ser = (serial_cnt + 1 >= SERIAL_WRAP) ? 0 : serial_cnt + 1;
                r.serial = 27'(ser);
                // opening word reserves room and lays down the header
                if (wr_phase == fmrb_pkg::PH_IDLE)
                begin
                    if (length_bad(w.len) ||
                        ring_free() < int'(w.len) + fmrb_pkg::HDR_BYTES)
                    begin
                        r.status = fmrb_pkg::ST_REJ;
                        wr_phase = w.last ? fmrb_pkg::PH_IDLE : fmrb_pkg::PH_DROP;
                    end
                    else
                    begin
                        base = commit_ptr;
                        ring_mem[base] = w.len[15:8];
                        ring_mem[(base + 1) % RING] = w.len[7:0];
                        ring_mem[(base + 2) % RING] = ser[31:24];
                        ring_mem[(base + 3) % RING] = ser[23:16];
                        ring_mem[(base + 4) % RING] = ser[15:8];
                        ring_mem[(base + 5) % RING] = ser[7:0];
                        wr_cursor = (base + fmrb_pkg::HDR_BYTES) % RING;
                        wr_taken = 0;
                        wr_phase = fmrb_pkg::PH_ACCEPT;
                    end
                end
                else if (wr_phase == fmrb_pkg::PH_DROP)
                begin
                    r.status = fmrb_pkg::ST_REJ;
                    if (w.last)
                        wr_phase = fmrb_pkg::PH_IDLE;
                end
                // payload byte
                if (wr_phase == fmrb_pkg::PH_ACCEPT && r.status == fmrb_pkg::ST_OK)
                begin
                    wlen = {ring_mem[commit_ptr], ring_mem[(commit_ptr + 1) % RING]};
                    if (wr_taken >= wlen)
                    begin
                        r.status = fmrb_pkg::ST_REJ;
                        wr_phase = w.last ? fmrb_pkg::PH_IDLE : fmrb_pkg::PH_DROP;
                    end
                    else
                    begin
                        ring_mem[wr_cursor] = w.data;
                        wr_cursor = (wr_cursor + 1) % RING;
                        wr_taken++;
                        if (w.last)
                        begin
                            if (wr_taken == wlen)
                            begin
                                commit_ptr = wr_cursor;
                                serial_cnt = ser;
                                if (msg_count < 4095)
                                    msg_count++;
                            end
                            else
                                r.status = fmrb_pkg::ST_REJ;
                            wr_phase = fmrb_pkg::PH_IDLE;
                        end
                    end
                end
            end
            fmrb_pkg::OP_READ:
            begin
                if (empty)
                    r.status = fmrb_pkg::ST_EMPTY;
                else if (rd_offset == 0 && length_bad(hlen))
                begin
                    // resync: drop everything committed
                    r.status = fmrb_pkg::ST_BAD;
                    rd_ptr = (commit_ptr + RING - 1) % RING;
                    msg_count = 0;
                end
                else if (rd_offset == 0 && int'(w.cap) < hlen)
                    r.status = fmrb_pkg::ST_CAP;
                else
                begin
                    r.data_byte_out = ring_mem[(hp + fmrb_pkg::HDR_BYTES + rd_offset) % RING];
                    rd_offset++;
                    if (rd_offset >= hlen)
                    begin
                        rd_ptr = (rd_ptr + fmrb_pkg::HDR_BYTES + hlen) % RING;
                        rd_offset = 0;
                        r.last_of_message = 1'b1;
                        if (msg_count > 0)
                            msg_count--;
                    end
                end
            end
            fmrb_pkg::OP_PEEK:
            begin
                if (empty)
                    r.status = fmrb_pkg::ST_EMPTY;
                else if (length_bad(hlen))
                    r.status = fmrb_pkg::ST_BAD;
                else if (int'(w.cap) < hlen)
                    r.status = fmrb_pkg::ST_CAP;
                else if (int'(w.poff) < hlen)
                    r.data_byte_out = ring_mem[(hp + fmrb_pkg::HDR_BYTES + w.poff) % RING];
            end
            default:
            begin
                rd_ptr = 0;
                commit_ptr = 1;
                wr_cursor = 1;
                wr_taken = 0;
                wr_phase = fmrb_pkg::PH_IDLE;
                rd_offset = 0;
                msg_count = 0;
            end
        endcase
        r.head_length = 16'(hlen);
        r.message_count = 12'(msg_count);
        r.free_bytes = 12'(ring_free());
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // sender: one word offered at a time from the pending queue
    always @(negedge clk)
    begin
        if (rst_n && !offering)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_word = pending_words.pop_front();
                offering = 1'b1;
                in_ch.valid <= 1'b1;
                in_ch.operation <= cur_word.op;
                in_ch.data_byte <= cur_word.data;
                in_ch.message_length <= cur_word.len;
                in_ch.last <= cur_word.last;
                in_ch.reader_capacity <= cur_word.cap;
                in_ch.peek_offset <= cur_word.poff;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // input acceptance feeds the predictor
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            predict_ring_word(cur_word);
            offering = 1'b0;
        end
    end

    // receiver stalls, with a long hold-off on request
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checking
    always @(posedge clk)
    begin
        fmrb_pkg::result_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.status !== want.status)
                    report_mismatch("status", out_ch.status, want.status);
                if (out_ch.data_byte_out !== want.data_byte_out)
                    report_mismatch("data_byte_out", out_ch.data_byte_out, want.data_byte_out);
                if (out_ch.head_length !== want.head_length)
                    report_mismatch("head_length", out_ch.head_length, want.head_length);
                if (out_ch.serial !== want.serial)
                    report_mismatch("serial", out_ch.serial, want.serial);
                if (out_ch.last_of_message !== want.last_of_message)
                    report_mismatch("last_of_message", out_ch.last_of_message,
                                    want.last_of_message);
                if (out_ch.message_count !== want.message_count)
                    report_mismatch("message_count", out_ch.message_count, want.message_count);
                if (out_ch.free_bytes !== want.free_bytes)
                    report_mismatch("free_bytes", out_ch.free_bytes, want.free_bytes);
            end
        end
    end

    task automatic add_word(input fmrb_pkg::op_t op, input int data, input int len,
                            input bit last, input int cap, input int poff);
        word_t w;
        w.op = op;
        w.data = 8'(data);
        w.len = 16'(len);
        w.last = last;
        w.cap = 16'(cap);
        w.poff = 11'(poff);
        pending_words.push_back(w);
    endtask

    // one message; mode 0 well formed, 1 too few bytes, 2 too many bytes
    task automatic add_message(input int len, input int n_bytes, input int mode);
        int cnt;
        int i;
        cnt = n_bytes;
        if (mode == 1 && cnt > 1)
            cnt = $urandom_range(cnt - 1, 1);
        else if (mode == 2)
            cnt = cnt + $urandom_range(3, 1);
        for (i = 0; i < cnt; i++)
            add_word(fmrb_pkg::OP_WRITE, $urandom_range(255),
                     (i == 0 || $urandom_range(1)) ? len : $urandom_range(65535),
                     i == cnt - 1, $urandom_range(65535), $urandom_range(2047));
    endtask

    // random words, write_pct weights message writes against reads, peeks, clears and stray writes
    task automatic add_random_words(input int n, input int write_pct);
        int start, r, len, k, i, mode;
        start = pending_words.size();
        while (pending_words.size() - start < n)
        begin
            r = $urandom_range(99);
            if (r < write_pct)
            begin
                k = $urandom_range(99);
                if (k < 80)
                    len = $urandom_range(24, 1);
                else if (k < 88)
                    len = $urandom_range(200, 25);
                else if (k < 92)
                    len = 0;
                else
                    len = $urandom_range(65535);
                k = $urandom_range(99);
                mode = (k < 10) ? 1 : (k < 18) ? 2 : 0;
                add_message(len, (len >= 1 && len <= 200) ? len : $urandom_range(3, 1), mode);
            end
            else if (r < write_pct + 35)
            begin
                k = $urandom_range(30, 1);
                for (i = 0; i < k; i++)
                    add_word(fmrb_pkg::OP_READ, $urandom_range(255), $urandom_range(65535),
                             $urandom_range(1),
                             ($urandom_range(4) == 0) ? $urandom_range(30)
                                                      : $urandom_range(65535, 200),
                             $urandom_range(2047));
            end
            else if (r < 97)
                add_word(fmrb_pkg::OP_PEEK, $urandom_range(255), $urandom_range(65535),
                         $urandom_range(1), $urandom_range(65535),
                         ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(30));
            else if (r < 99)
                add_word(fmrb_pkg::OP_CLEAR, $urandom_range(255), $urandom_range(65535),
                         $urandom_range(1), $urandom_range(65535), $urandom_range(2047));
            else
                add_word(fmrb_pkg::OP_WRITE, $urandom_range(255), $urandom_range(65535),
                         $urandom_range(1), $urandom_range(65535), $urandom_range(2047));
        end
    endtask

    // wait until every word is sent and every result is back, then let the block settle
    task automatic wait_idle();
        while (pending_words.size() > 0 || offering || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 12'(value);
        max_len = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int limit, input int send_pct, input int recv_pct,
                             input int n, input int write_pct);
        wait_idle();
        write_limit(limit);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        add_random_words(n, write_pct);
    endtask

    // stimulus
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.operation = fmrb_pkg::OP_WRITE;
        in_ch.data_byte = '0;
        in_ch.message_length = '0;
        in_ch.last = 1'b0;
        in_ch.reader_capacity = '0;
        in_ch.peek_offset = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        offering = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rx_hold_left = 0;
        mismatches = 0;
        rd_ptr = 0;
        commit_ptr = 1;
        wr_cursor = 1;
        wr_taken = 0;
        wr_phase = fmrb_pkg::PH_IDLE;
        rd_offset = 0;
        serial_cnt = 0;
        msg_count = 0;
        max_len = 2048;
        foreach (ring_mem[i])
            ring_mem[i] = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty ring, smallest message, capacity, peeks, bad lengths, framing errors
        add_word(fmrb_pkg::OP_READ, 0, 0, 0, 65535, 0);
        add_word(fmrb_pkg::OP_PEEK, 0, 0, 0, 65535, 0);
        add_word(fmrb_pkg::OP_WRITE, 255, 1, 1, 0, 0);
        add_word(fmrb_pkg::OP_READ, 0, 0, 0, 0, 0);
        add_word(fmrb_pkg::OP_PEEK, 0, 0, 0, 0, 0);
        add_word(fmrb_pkg::OP_PEEK, 0, 0, 0, 65535, 2047);
        add_word(fmrb_pkg::OP_PEEK, 0, 0, 0, 1, 0);
        add_word(fmrb_pkg::OP_READ, 0, 0, 0, 1, 0);
        add_word(fmrb_pkg::OP_WRITE, 0, 0, 1, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 1, 65535, 0, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 2, 0, 1, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 3, 2049, 1, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 170, 3, 0, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 85, 3, 1, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 7, 1, 0, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 8, 1, 1, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 9, 2, 0, 0, 0);
        add_word(fmrb_pkg::OP_WRITE, 10, 65535, 1, 0, 0);
        add_word(fmrb_pkg::OP_PEEK, 0, 0, 0, 2, 1);
        add_word(fmrb_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        add_word(fmrb_pkg::OP_READ, 0, 0, 0, 65535, 0);
        add_word(fmrb_pkg::OP_WRITE, 0, 2048, 1, 0, 0);
        add_random_words(180, 45);

        run_phase(4095, 64, 0, 170, 45);
        run_phase(0, 0, 64, 170, 45);
        // no limit: only room can reject a huge length
        add_word(fmrb_pkg::OP_WRITE, 1, 65535, 1, 0, 0);
        run_phase(100, 6, 6, 170, 45);

        // receiver holds off while writes pile up
        run_phase(2048, 0, 0, 0, 45);
        rx_hold_left = 400;
        add_random_words(170, 85);

        // lowered limit turns stored headers bad
        run_phase(1, 30, 30, 120, 30);
        run_phase(2048, 20, 20, 150, 45);

        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fmrb_pkg.sv
hw/rtl/fmrb_if.sv
hw/rtl/fmrb_ram.sv
hw/rtl/fmrb_ctrl.sv
hw/rtl/framed_message_ring_buffer_unit.sv
tb/tb_framed_message_ring_buffer_unit.sv
